@@ rtl/assert_macros.svh @@
// assertion macros shared by the colormap rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define CMI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// clocked check that also holds through reset
`define CMI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/cmi_pkg.sv @@
// shared types and constants for the colormap interpolation block
package cmi_pkg;

    // default parameter values
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_BLEND_BITS  = 8;

    // fixed field widths
    localparam int NORM_W  = 16;
    localparam int COUNT_W = 9;

    localparam logic [NORM_W-1:0] NORM_MAX    = '1;
    localparam logic [7:0]        ALPHA_VALUE = 8'hFF;

    // request kinds carried on tuser
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_VALUE_MIN   = 2'd0;
    localparam logic [1:0] REG_VALUE_SCALE = 2'd1;
    localparam logic [1:0] REG_COLOR_COUNT = 2'd2;

    // configuration reset values
    localparam logic signed [31:0] RST_VALUE_MIN   = 32'sd0;
    localparam logic [31:0]        RST_VALUE_SCALE = 32'd65536;
    localparam logic [COUNT_W-1:0] RST_COLOR_COUNT = 9'd256;

    // one accepted request
    typedef struct packed {
        logic        is_sample;
        logic [31:0] sample;
        logic [7:0]  entry_index;
        logic [23:0] entry_rgb;
    } item_t;

    // control bits that travel with each pipeline stage
    typedef struct packed {
        logic vld;
        logic is_sample;
        logic sat;
    } ctl_t;

endpackage

@@ rtl/colormap_interpolate_rgba.sv @@
// colormap lookup with linear blending, one request per clock
// an accepted sample request passes the offset, scale, saturate, index, table read and output registers to m_tvalid
// throughput: 1 request per cycle; the six stage pipeline stalls as a whole on m_tready
// table writes pass the same pipeline and update the table in request order, no output
// reset: aresetn synchronous active low clears valid bits and configuration registers
// the color table is not cleared; entries read before being written are undefined
`include "assert_macros.svh"

module colormap_interpolate_rgba #(
    parameter int TABLE_DEPTH = cmi_pkg::DEF_TABLE_DEPTH,
    parameter int BLEND_BITS  = cmi_pkg::DEF_BLEND_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_value[31:0], entry_index[39:32], entry_red[47:40], entry_green[55:48],
    // entry_blue[63:56]
    input  logic [63:0] s_tdata,
    // req_type[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16], pixel_alpha[31:24]
    output logic [31:0] m_tdata,
    // was_saturated[0]
    output logic [0:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic                               adv;
    cmi_pkg::item_t                     in_item;
    logic signed [31:0]                 value_min_reg;
    logic [31:0]                        value_scale_reg;
    logic [cmi_pkg::COUNT_W-1:0]        color_count_reg;

    cmi_pkg::ctl_t                      norm_ctl;
    logic [cmi_pkg::NORM_W-1:0]         norm_val;
    logic [7:0]                         norm_wr_index;
    logic [23:0]                        norm_wr_rgb;

    cmi_pkg::ctl_t                      lk_ctl;
    logic [BLEND_BITS-1:0]              lk_frac;
    logic [23:0]                        lk_e0;
    logic [23:0]                        lk_e1;

    logic                               out_sat;

    // whole pipeline moves unless a result waits
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // unpack the request
    always_comb begin
        in_item.is_sample   = (s_tuser[0] == cmi_pkg::REQ_SAMPLE);
        in_item.sample      = s_tdata[31:0];
        in_item.entry_index = s_tdata[39:32];
        in_item.entry_rgb   = {s_tdata[47:40], s_tdata[55:48], s_tdata[63:56]};
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_min_reg   <= cmi_pkg::RST_VALUE_MIN;
            value_scale_reg <= cmi_pkg::RST_VALUE_SCALE;
            color_count_reg <= cmi_pkg::RST_COLOR_COUNT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cmi_pkg::REG_VALUE_MIN: begin
                    value_min_reg <= cfg_wdata;
                end
                cmi_pkg::REG_VALUE_SCALE: begin
                    value_scale_reg <= cfg_wdata;
                end
                cmi_pkg::REG_COLOR_COUNT: begin
                    color_count_reg <= cfg_wdata[cmi_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    cmi_norm u_norm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_vld       (s_tvalid),
        .in_item      (in_item),
        .value_min    (value_min_reg),
        .value_scale  (value_scale_reg),
        .out_ctl      (norm_ctl),
        .out_norm     (norm_val),
        .out_wr_index (norm_wr_index),
        .out_wr_rgb   (norm_wr_rgb)
    );

    cmi_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .BLEND_BITS  (BLEND_BITS)
    ) u_lookup (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_ctl      (norm_ctl),
        .in_norm     (norm_val),
        .in_wr_index (norm_wr_index),
        .in_wr_rgb   (norm_wr_rgb),
        .color_count (color_count_reg),
        .out_ctl     (lk_ctl),
        .out_frac    (lk_frac),
        .out_e0      (lk_e0),
        .out_e1      (lk_e1)
    );

    cmi_blend #(
        .BLEND_BITS (BLEND_BITS)
    ) u_blend (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_ctl   (lk_ctl),
        .in_frac  (lk_frac),
        .in_e0    (lk_e0),
        .in_e1    (lk_e1),
        .out_vld  (m_tvalid),
        .out_rgba (m_tdata),
        .out_sat  (out_sat)
    );

    assign m_tuser[0] = out_sat;

    // nothing comes out right after reset
    `CMI_ASSERT_ALWAYS(a_quiet_after_reset, aclk, !aresetn |=> !m_tvalid, "result right after reset")
    // every pixel is opaque
    `CMI_ASSERT(a_alpha_opaque, aclk, aresetn, m_tvalid |-> m_tdata[31:24] == cmi_pkg::ALPHA_VALUE, "alpha not opaque")
    // a blocked result keeps the intake closed
    `CMI_ASSERT(a_stall_closes_intake, aclk, aresetn, m_tvalid && !m_tready |-> !s_tready, "request taken while output blocked")

endmodule

@@ rtl/cmi_norm.sv @@
// offset, scale and saturate stages producing the q0.16 normalized sample
`include "assert_macros.svh"

module cmi_norm (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_vld,
    input  cmi_pkg::item_t              in_item,
    input  logic signed [31:0]          value_min,
    input  logic [31:0]                 value_scale,
    output cmi_pkg::ctl_t               out_ctl,
    output logic [cmi_pkg::NORM_W-1:0]  out_norm,
    output logic [7:0]                  out_wr_index,
    output logic [23:0]                 out_wr_rgb
);

    // stage 1: offset
    logic        s1_vld_reg;
    logic        s1_sample_reg;
    logic [32:0] s1_diff_reg;
    logic [32:0] s1_diff_next;
    logic [7:0]  s1_idx_reg;
    logic [23:0] s1_rgb_reg;

    // stage 2: scale product
    logic        s2_vld_reg;
    logic        s2_sample_reg;
    logic        s2_neg_reg;
    logic [63:0] s2_prod_reg;
    logic [63:0] s2_prod_next;
    logic [7:0]  s2_idx_reg;
    logic [23:0] s2_rgb_reg;

    // stage 3: saturate
    cmi_pkg::ctl_t               s3_ctl_reg;
    cmi_pkg::ctl_t               s3_ctl_next;
    logic [cmi_pkg::NORM_W-1:0]  s3_norm_reg;
    logic [cmi_pkg::NORM_W-1:0]  s3_norm_next;
    logic [7:0]                  s3_idx_reg;
    logic [23:0]                 s3_rgb_reg;

    // sign-extended difference, 33 bits never overflow
    assign s1_diff_next = {in_item.sample[31], in_item.sample} - {value_min[31], value_min};

    // 32x32 product of the non-negative difference
    assign s2_prod_next = {32'd0, s1_diff_reg[31:0]} * {32'd0, value_scale};

    // clamp to 0 below min, to the top above 1.0
    always_comb begin
        s3_ctl_next.vld       = s2_vld_reg;
        s3_ctl_next.is_sample = s2_sample_reg;
        if (s2_neg_reg) begin
            s3_norm_next    = '0;
            s3_ctl_next.sat = 1'b1;
        end else if (|s2_prod_reg[63:32]) begin
            s3_norm_next    = cmi_pkg::NORM_MAX;
            s3_ctl_next.sat = 1'b1;
        end else begin
            s3_norm_next    = s2_prod_reg[31:16];
            s3_ctl_next.sat = 1'b0;
        end
    end

    // valid bits with reset, payload without
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            s3_ctl_reg.vld <= 1'b0;
        end else if (adv) begin
            s1_vld_reg     <= in_vld;
            s2_vld_reg     <= s1_vld_reg;
            s3_ctl_reg.vld <= s3_ctl_next.vld;
        end
        if (adv) begin
            s1_sample_reg        <= in_item.is_sample;
            s1_diff_reg          <= s1_diff_next;
            s1_idx_reg           <= in_item.entry_index;
            s1_rgb_reg           <= in_item.entry_rgb;
            s2_sample_reg        <= s1_sample_reg;
            s2_neg_reg           <= s1_diff_reg[32];
            s2_prod_reg          <= s2_prod_next;
            s2_idx_reg           <= s1_idx_reg;
            s2_rgb_reg           <= s1_rgb_reg;
            s3_ctl_reg.is_sample <= s3_ctl_next.is_sample;
            s3_ctl_reg.sat       <= s3_ctl_next.sat;
            s3_norm_reg          <= s3_norm_next;
            s3_idx_reg           <= s2_idx_reg;
            s3_rgb_reg           <= s2_rgb_reg;
        end
    end

    assign out_ctl      = s3_ctl_reg;
    assign out_norm     = s3_norm_reg;
    assign out_wr_index = s3_idx_reg;
    assign out_wr_rgb   = s3_rgb_reg;

    // a clamped sample sits at one of the two ends
    `CMI_ASSERT(a_sat_at_end, aclk, aresetn, s3_ctl_reg.vld && s3_ctl_reg.is_sample && s3_ctl_reg.sat |-> s3_norm_reg == '0 || s3_norm_reg == cmi_pkg::NORM_MAX, "saturated norm not at an end")

endmodule

@@ rtl/cmi_lookup.sv @@
// entry index stage and color table read stage
`include "assert_macros.svh"

module cmi_lookup #(
    parameter int TABLE_DEPTH = cmi_pkg::DEF_TABLE_DEPTH,
    parameter int BLEND_BITS  = cmi_pkg::DEF_BLEND_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  cmi_pkg::ctl_t                in_ctl,
    input  logic [cmi_pkg::NORM_W-1:0]   in_norm,
    input  logic [7:0]                   in_wr_index,
    input  logic [23:0]                  in_wr_rgb,
    input  logic [cmi_pkg::COUNT_W-1:0]  color_count,
    output cmi_pkg::ctl_t                out_ctl,
    output logic [BLEND_BITS-1:0]        out_frac,
    output logic [23:0]                  out_e0,
    output logic [23:0]                  out_e1
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > cmi_pkg::COUNT_W) ? CNT_W : cmi_pkg::COUNT_W;
    localparam int POS_W = cmi_pkg::NORM_W + CNT_W;

    logic [CMP_W-1:0] count_wide;
    logic [CMP_W-1:0] count_clamp;
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] last;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] idx_raw;
    logic [CNT_W-1:0] idx_c;
    logic [CNT_W-1:0] nxt_c;
    logic [CMP_W-1:0] wr_wide;

    // stage 4: index and blend fraction
    cmi_pkg::ctl_t           s4_ctl_reg;
    logic [IDX_W-1:0]        s4_idx_reg;
    logic [IDX_W-1:0]        s4_nxt_reg;
    logic [BLEND_BITS-1:0]   s4_frac_reg;
    logic                    s4_wr_ok_reg;
    logic [IDX_W-1:0]        s4_wr_addr_reg;
    logic [23:0]             s4_rgb_reg;

    // stage 5: table read
    cmi_pkg::ctl_t           s5_ctl_reg;
    logic [BLEND_BITS-1:0]   s5_frac_reg;
    logic [23:0]             s5_e0_reg;
    logic [23:0]             s5_e1_reg;

    logic [23:0] table_mem [TABLE_DEPTH];

    // count in use, zero read as one, clamped to the table size
    always_comb begin
        count_wide = CMP_W'(color_count);
        if (count_wide == '0) begin
            count_clamp = CMP_W'(1);
        end else if (count_wide > CMP_W'(TABLE_DEPTH)) begin
            count_clamp = CMP_W'(TABLE_DEPTH);
        end else begin
            count_clamp = count_wide;
        end
        count_eff = count_clamp[CNT_W-1:0];
        last      = count_eff - CNT_W'(1);
    end

    // entry position and neighbor, both kept inside the used range
    always_comb begin
        pos     = POS_W'(in_norm) * POS_W'(count_eff);
        idx_raw = pos[POS_W-1:cmi_pkg::NORM_W];
        idx_c   = (idx_raw > last) ? last : idx_raw;
        nxt_c   = (idx_c < last) ? idx_c + CNT_W'(1) : last;
        wr_wide = CMP_W'(in_wr_index);
    end

    // valid bits with reset, payload without
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_ctl_reg.vld <= 1'b0;
            s5_ctl_reg.vld <= 1'b0;
        end else if (adv) begin
            s4_ctl_reg.vld <= in_ctl.vld;
            s5_ctl_reg.vld <= s4_ctl_reg.vld;
        end
        if (adv) begin
            s4_ctl_reg.is_sample <= in_ctl.is_sample;
            s4_ctl_reg.sat       <= in_ctl.sat;
            s4_idx_reg           <= idx_c[IDX_W-1:0];
            s4_nxt_reg           <= nxt_c[IDX_W-1:0];
            s4_frac_reg          <= pos[cmi_pkg::NORM_W-1 -: BLEND_BITS];
            s4_wr_ok_reg         <= wr_wide < CMP_W'(TABLE_DEPTH);
            s4_wr_addr_reg       <= wr_wide[IDX_W-1:0];
            s4_rgb_reg           <= in_wr_rgb;
            s5_ctl_reg.is_sample <= s4_ctl_reg.is_sample;
            s5_ctl_reg.sat       <= s4_ctl_reg.sat;
            s5_frac_reg          <= s4_frac_reg;
        end
    end

    // table: one write port, two registered read ports, in request order
    always_ff @(posedge aclk) begin
        if (adv && s4_ctl_reg.vld) begin
            if (s4_ctl_reg.is_sample) begin
                s5_e0_reg <= table_mem[s4_idx_reg];
                s5_e1_reg <= table_mem[s4_nxt_reg];
            end else if (s4_wr_ok_reg) begin
                table_mem[s4_wr_addr_reg] <= s4_rgb_reg;
            end
        end
    end

    assign out_ctl  = s5_ctl_reg;
    assign out_frac = s5_frac_reg;
    assign out_e0   = s5_e0_reg;
    assign out_e1   = s5_e1_reg;

    // neighbor is the same entry or the one after it
    `CMI_ASSERT(a_nxt_follows, aclk, aresetn, s4_ctl_reg.vld && s4_ctl_reg.is_sample |-> s4_nxt_reg == s4_idx_reg || s4_nxt_reg == s4_idx_reg + IDX_W'(1), "neighbor entry out of order")

endmodule

@@ rtl/cmi_blend.sv @@
// channel blend stage and output register
module cmi_blend #(
    parameter int BLEND_BITS = cmi_pkg::DEF_BLEND_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  cmi_pkg::ctl_t          in_ctl,
    input  logic [BLEND_BITS-1:0]  in_frac,
    input  logic [23:0]            in_e0,
    input  logic [23:0]            in_e1,
    output logic                   out_vld,
    output logic [31:0]            out_rgba,
    output logic                   out_sat
);

    localparam int PW = BLEND_BITS + 9;
    localparam logic [BLEND_BITS:0] ONE = (BLEND_BITS + 1)'(1) << BLEND_BITS;

    logic        out_vld_reg;
    logic [31:0] out_rgba_reg;
    logic [31:0] out_rgba_next;
    logic        out_sat_reg;

    // weighted sum of two bytes, truncated
    function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                       input logic [BLEND_BITS-1:0] frac);
        logic [PW-1:0] wa;
        logic [PW-1:0] wb;
        logic [PW:0]   sum;
        wa  = PW'(ONE - (BLEND_BITS + 1)'(frac)) * PW'(a);
        wb  = PW'(frac) * PW'(b);
        sum = (PW + 1)'(wa) + (PW + 1)'(wb);
        return sum[BLEND_BITS +: 8];
    endfunction

    // red, green, blue, alpha from the low byte up
    always_comb begin
        out_rgba_next[7:0]   = mix(in_e0[23:16], in_e1[23:16], in_frac);
        out_rgba_next[15:8]  = mix(in_e0[15:8], in_e1[15:8], in_frac);
        out_rgba_next[23:16] = mix(in_e0[7:0], in_e1[7:0], in_frac);
        out_rgba_next[31:24] = cmi_pkg::ALPHA_VALUE;
    end

    // only sample requests leave a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= in_ctl.vld && in_ctl.is_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_rgba_reg <= out_rgba_next;
            out_sat_reg  <= in_ctl.sat;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_rgba = out_rgba_reg;
    assign out_sat  = out_sat_reg;

endmodule
